>>> hdl/ptca_pkg.sv
// ----------------------------------------------------------------------------
// ptca_pkg
// Shared constants, codes and types for the path tree common ancestor block.
// ----------------------------------------------------------------------------
package ptca_pkg;

   localparam int MAX_NODES = 1024;
   localparam int IDX_SPAN  = 1024;
   localparam int CAPACITY  = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = $clog2(IDX_SPAN + 1);
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_APPEND = 2'd0;
   localparam op_type OP_LCA    = 2'd1;
   localparam op_type OP_ANC    = 2'd2;
   localparam op_type OP_CLEAR  = 2'd3;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_RANGE = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;
   localparam status_type STAT_BAD   = 2'd3;

   typedef struct packed {
      op_type  op;
      idx_type node_a;
      idx_type node_b;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic       is_ancestor;
      idx_type    result_node;
   } rsp_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      idx_type  wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } ram_req_type;

endpackage

>>> hdl/ptca_parent_ram.sv
// ----------------------------------------------------------------------------
// ptca_parent_ram
// Parent table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptca_parent_ram (
   input  logic                  clock,
   input  ptca_pkg::ram_req_type ram_req,
   output ptca_pkg::idx_type     rd_data
);

   ptca_pkg::idx_type parent_mem_ff [ptca_pkg::CAPACITY];
   ptca_pkg::idx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         parent_mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= parent_mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ptca_seq.sv
// ----------------------------------------------------------------------------
// ptca_seq
// Sequencer: range checks, appends, clears, and the parent walk that steps one node
// per table read through a shared index comparator.
// ----------------------------------------------------------------------------
module ptca_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ptca_pkg::cmd_type     cmd,
   input  logic                  out_free,
   input  ptca_pkg::idx_type     rd_data,
   output logic                  idle,
   output logic                  done,
   output ptca_pkg::rsp_type     rsp,
   output ptca_pkg::ram_req_type ram_req
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                pend_ff, pend_in;
   ptca_pkg::op_type    op_ff, op_in;
   ptca_pkg::idx_type   a_ff, a_in;
   ptca_pkg::idx_type   b_ff, b_in;
   ptca_pkg::cnt_type   count_ff, count_in;
   logic                sel_b_ff, sel_b_in;
   ptca_pkg::rsp_type   rsp_ff, rsp_in;

   // shared comparator
   logic                a_eq_b;
   logic                a_lt_b;
   logic                a_oor;
   logic                b_oor;

   assign a_eq_b = (a_ff == b_ff);
   assign a_lt_b = (a_ff < b_ff);
   assign a_oor  = (ptca_pkg::cnt_type'(a_ff) >= count_ff);
   assign b_oor  = (ptca_pkg::cnt_type'(b_ff) >= count_ff);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      count_in = count_ff;
      sel_b_in = sel_b_ff;
      rsp_in   = rsp_ff;
      ram_req  = '0;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (pend_ff) begin
               if (out_free) begin
                  done    = 1'b1;
                  pend_in = 1'b0;
               end
            end else if (start) begin
               op_in    = cmd.op;
               a_in     = cmd.node_a;
               b_in     = cmd.node_b;
               rsp_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_IDLE;
            pend_in  = 1'b1;
            unique case (op_ff)
               ptca_pkg::OP_APPEND: begin
                  if (a_oor) begin
                     rsp_in.status = ptca_pkg::STAT_RANGE;
                  end else if (count_ff >= ptca_pkg::cnt_type'(ptca_pkg::CAPACITY)) begin
                     rsp_in.status = ptca_pkg::STAT_FULL;
                  end else begin
                     ram_req.wr_en      = 1'b1;
                     ram_req.wr_addr    = count_ff[ptca_pkg::ADDR_W-1:0];
                     ram_req.wr_data    = a_ff;
                     rsp_in.result_node = count_ff[ptca_pkg::IDX_W-1:0];
                     count_in           = count_ff + ptca_pkg::cnt_type'(1);
                  end
               end
               ptca_pkg::OP_CLEAR: begin
                  count_in = ptca_pkg::cnt_type'(1);
               end
               default: begin
                  if (a_oor || b_oor) begin
                     rsp_in.status = ptca_pkg::STAT_RANGE;
                  end else if (op_ff == ptca_pkg::OP_ANC && a_ff == '0) begin
                     rsp_in.is_ancestor = 1'b1;
                  end else begin
                     pend_in  = 1'b0;
                     state_in = S_WALK;
                  end
               end
            endcase
         end
         S_WALK: begin
            if (op_ff == ptca_pkg::OP_LCA) begin
               if (a_eq_b) begin
                  rsp_in.result_node = a_ff;
                  pend_in            = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  sel_b_in        = a_lt_b;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = a_lt_b ? b_ff[ptca_pkg::ADDR_W-1:0]
                                           : a_ff[ptca_pkg::ADDR_W-1:0];
                  state_in        = S_LOAD;
               end
            end else begin
               priority if (b_ff == '0) begin
                  pend_in  = 1'b1;
                  state_in = S_IDLE;
               end else if (a_eq_b) begin
                  rsp_in.is_ancestor = 1'b1;
                  pend_in            = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  sel_b_in        = 1'b1;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = b_ff[ptca_pkg::ADDR_W-1:0];
                  state_in        = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (sel_b_ff) begin
               b_in = rd_data;
            end else begin
               a_in = rd_data;
            end
            state_in = S_WALK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= ptca_pkg::cnt_type'(1);
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      sel_b_ff <= sel_b_in;
      rsp_ff   <= rsp_in;
   end

   assign idle = (state_ff == S_IDLE) && !pend_ff;
   assign rsp  = rsp_ff;

endmodule

>>> hdl/path_tree_common_ancestor.sv
// ----------------------------------------------------------------------------
// path_tree_common_ancestor
// Tree kept as a parent table: append, lowest common ancestor, ancestor
// test and clear, one transaction at a time.
//
//   channel  | dir | tdata fields (lsb first)
//   ---------+-----+-------------------------------------------------
//   req_     | in  | opcode[1:0], node_a[11:2], node_b[21:12]
//   rsp_     | out | result_node[9:0], is_ancestor[10], status[12:11]
//
// Append, clear and rejected queries go through a check step, then wait
// until the output register is free. Queries walk one parent link per table
// read, through the single read port and its registered data.
// req_tready is low while a transaction is in the sequencer; one finished
// result may wait in the output register while the next is taken.
// Synchronous reset leaves the root alone in the table; no clearing pass.
// ----------------------------------------------------------------------------
module path_tree_common_ancestor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode, node_a, node_b, 2'b0
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // result_node, is_ancestor, status, 3'b0
);

   ptca_pkg::cmd_type     cmd;
   ptca_pkg::rsp_type     seq_rsp;
   ptca_pkg::rsp_type     rsp_data_ff;
   ptca_pkg::ram_req_type ram_req;
   ptca_pkg::idx_type     rd_data;
   logic                  seq_idle;
   logic                  seq_done;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign cmd.op     = req_tdata[1:0];
   assign cmd.node_a = req_tdata[11:2];
   assign cmd.node_b = req_tdata[21:12];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = seq_idle;

   ptca_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && seq_idle),
      .cmd      (cmd),
      .out_free (out_free),
      .rd_data  (rd_data),
      .idle     (seq_idle),
      .done     (seq_done),
      .rsp      (seq_rsp),
      .ram_req  (ram_req)
   );

   ptca_parent_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign rsp_valid_in = seq_done || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

>>> hdl/ptca_checker.sv
// ----------------------------------------------------------------------------
// ptca_checker
// Port-level checks for path_tree_common_ancestor, bound to the top level.
// ----------------------------------------------------------------------------
module ptca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   ap_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   ap_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:11] != ptca_pkg::STAT_BAD)
      else $error("undefined status code");

   ap_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:11] != ptca_pkg::STAT_OK
      |-> rsp_tdata[9:0] == 10'd0 && !rsp_tdata[10])
      else $error("error response carries a result");

   ap_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

endmodule

bind path_tree_common_ancestor ptca_checker u_ptca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/path_tree_common_ancestor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_tree_common_ancestor_tb
// Self-checking bench for the parent-table tree. A scoreboard keeps its own
// copy of the tree and predicts every answer. Stimulus is a short directed
// pass, then random trees, bushy and chain-like, with queries mixed in.
// Both stream sides idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------

class ancestry_tracker;
   ptca_pkg::idx_type parent_of [ptca_pkg::CAPACITY];
   int unsigned       node_count;
   ptca_pkg::rsp_type due_answers [$];
   int unsigned       errors;
   int unsigned       items_noted;
   int unsigned       op_seen [4];
   int unsigned       status_seen [3];
   int unsigned       deepest_walk;

   function new();
      clear_tree();
      errors       = 0;
      items_noted  = 0;
      deepest_walk = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function void clear_tree();
      node_count   = 1;
      parent_of[0] = '0;
   endfunction

   function void report_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
   endfunction

   function void note_request(ptca_pkg::op_type op, ptca_pkg::idx_type node_a,
                              ptca_pkg::idx_type node_b);
      ptca_pkg::rsp_type r;
      int unsigned       a, b, walk;
      r    = '0;
      a    = node_a;
      b    = node_b;
      walk = 0;
      case (op)
         ptca_pkg::OP_APPEND: begin
            if (a >= node_count) begin
               r.status = ptca_pkg::STAT_RANGE;
            end else if (node_count >= ptca_pkg::CAPACITY) begin
               r.status = ptca_pkg::STAT_FULL;
            end else begin
               parent_of[node_count] = ptca_pkg::idx_type'(a);
               r.result_node = ptca_pkg::idx_type'(node_count);
               node_count++;
            end
         end
         ptca_pkg::OP_LCA: begin
            if (a >= node_count || b >= node_count) begin
               r.status = ptca_pkg::STAT_RANGE;
            end else begin
               while (a != b) begin
                  if (a < b) b = parent_of[b];
                  else a = parent_of[a];
                  walk++;
               end
               r.result_node = ptca_pkg::idx_type'(a);
            end
         end
         ptca_pkg::OP_ANC: begin
            if (a >= node_count || b >= node_count) begin
               r.status = ptca_pkg::STAT_RANGE;
            end else if (a == 0) begin
               r.is_ancestor = 1'b1;
            end else begin
               while (b != 0) begin
                  if (a == b) begin
                     r.is_ancestor = 1'b1;
                     break;
                  end
                  b = parent_of[b];
                  walk++;
               end
            end
         end
         ptca_pkg::OP_CLEAR: begin
            clear_tree();
         end
      endcase
      if (walk > deepest_walk) deepest_walk = walk;
      op_seen[op]++;
      status_seen[r.status]++;
      items_noted++;
      due_answers = {due_answers, r};
   endfunction

   function void check_response(logic [15:0] data);
      ptca_pkg::rsp_type got, want;
      got = ptca_pkg::rsp_type'(data[12:0]);
      if (due_answers.size() == 0) begin
         report_error($sformatf("unexpected response %h", data));
         return;
      end
      want = due_answers.pop_front();
      if (got.result_node !== want.result_node || got.is_ancestor !== want.is_ancestor ||
          got.status !== want.status)
         report_error($sformatf({"expected node %0d anc %0b status %0d, ",
                                 "got node %0d anc %0b status %0d"},
                                want.result_node, want.is_ancestor, want.status,
                                got.result_node, got.is_ancestor, got.status));
   endfunction

   function void check_drained();
      if (due_answers.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", due_answers.size()));
         errors += due_answers.size() - 1;
      end
   endfunction
endclass

module path_tree_common_ancestor_tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // opcode, node_a, node_b, 2'b0
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // result_node, is_ancestor, status, 3'b0

   bit              steady = 1'b0;
   ancestry_tracker sb     = new();

   path_tree_common_ancestor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   task automatic send_cmd(ptca_pkg::op_type op, ptca_pkg::idx_type a,
                           ptca_pkg::idx_type b);
      @(negedge clock);
      if (!steady && $urandom_range(4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, b, a, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, a, b);
   endtask

   task automatic random_append(int unsigned chain_pct);
      int unsigned n, a;
      n = sb.node_count;
      if ($urandom_range(19) == 0 && n < ptca_pkg::CAPACITY)
         a = $urandom_range(ptca_pkg::CAPACITY - 1, n);
      else if ($urandom_range(99) < chain_pct) a = n - 1;
      else a = $urandom_range(n - 1);
      send_cmd(ptca_pkg::OP_APPEND, ptca_pkg::idx_type'(a), ptca_pkg::idx_type'($urandom));
   endtask

   task automatic random_query();
      ptca_pkg::op_type op;
      int unsigned      n, a, b, pick, tmp;
      n    = sb.node_count;
      op   = $urandom_range(1) ? ptca_pkg::OP_LCA : ptca_pkg::OP_ANC;
      a    = $urandom_range(n - 1);
      b    = $urandom_range(n - 1);
      pick = $urandom_range(9);
      if (pick == 0 && n < ptca_pkg::CAPACITY) begin
         if ($urandom_range(1)) a = $urandom_range(ptca_pkg::CAPACITY - 1, n);
         else b = $urandom_range(ptca_pkg::CAPACITY - 1, n);
      end else if (pick < 6) begin
         // a on the path from b up to the root (swapped when pick is 5)
         a = b;
         repeat ($urandom_range(6)) a = sb.parent_of[a];
         if (pick == 5) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
      end
      send_cmd(op, ptca_pkg::idx_type'(a), ptca_pkg::idx_type'(b));
   endtask

   task automatic grow_tree(int unsigned n_ops, int unsigned chain_pct, int unsigned query_pct);
      repeat (n_ops) begin
         if ($urandom_range(99) < query_pct) random_query();
         else random_append(chain_pct);
      end
   endtask

   initial begin : rsp_sink
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (!hold_done && sb.items_noted >= 150) begin
            hold_done  = 1'b1;
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end else if (steady || $urandom_range(3) != 0) begin
            rsp_tready = 1'b1;
            repeat (steady ? 1 : $urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned guard;
      int unsigned chain_pct;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // root alone, then missing nodes and parents
      send_cmd(ptca_pkg::OP_LCA,    10'd0,    10'd0);
      send_cmd(ptca_pkg::OP_ANC,    10'd0,    10'd0);
      send_cmd(ptca_pkg::OP_ANC,    10'd1,    10'd0);
      send_cmd(ptca_pkg::OP_LCA,    10'd0,    10'd1023);
      send_cmd(ptca_pkg::OP_APPEND, 10'd1023, 10'd0);
      send_cmd(ptca_pkg::OP_APPEND, 10'd1,    10'd1023);
      // small tree: 1,4 under root; 2,3 under 1
      send_cmd(ptca_pkg::OP_APPEND, 10'd0,    10'd1023);
      send_cmd(ptca_pkg::OP_APPEND, 10'd1,    10'd0);
      send_cmd(ptca_pkg::OP_APPEND, 10'd1,    10'd0);
      send_cmd(ptca_pkg::OP_APPEND, 10'd0,    10'd0);
      send_cmd(ptca_pkg::OP_LCA,    10'd2,    10'd3);
      send_cmd(ptca_pkg::OP_LCA,    10'd3,    10'd4);
      send_cmd(ptca_pkg::OP_LCA,    10'd2,    10'd2);
      send_cmd(ptca_pkg::OP_LCA,    10'd1,    10'd3);
      send_cmd(ptca_pkg::OP_ANC,    10'd1,    10'd3);
      send_cmd(ptca_pkg::OP_ANC,    10'd3,    10'd1);
      send_cmd(ptca_pkg::OP_ANC,    10'd0,    10'd4);
      send_cmd(ptca_pkg::OP_ANC,    10'd2,    10'd3);
      send_cmd(ptca_pkg::OP_ANC,    10'd4,    10'd4);
      send_cmd(ptca_pkg::OP_ANC,    10'd1023, 10'd0);
      send_cmd(ptca_pkg::OP_LCA,    10'd0,    10'd5);
      send_cmd(ptca_pkg::OP_CLEAR,  10'd1023, 10'd1023);
      send_cmd(ptca_pkg::OP_LCA,    10'd1,    10'd0);
      send_cmd(ptca_pkg::OP_APPEND, 10'd0,    10'd0);

      while (sb.items_noted < 720) begin
         if ($urandom_range(9) < 7)
            send_cmd(ptca_pkg::OP_CLEAR, ptca_pkg::idx_type'($urandom),
                     ptca_pkg::idx_type'($urandom));
         case ($urandom_range(2))
            0: chain_pct = 0;
            1: chain_pct = 30;
            default: chain_pct = 90;
         endcase
         grow_tree($urandom_range(8, 80), chain_pct, $urandom_range(30, 60));
      end

      steady = 1'b1;
      grow_tree(850 - sb.items_noted, 15, 80);
      @(negedge clock);
      req_tvalid = 1'b0;

      guard = 0;
      while (sb.due_answers.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      sb.check_drained();

      $display("Ran %0d transactions: %0d append, %0d common ancestor, %0d ancestor test, %0d clear.",
               sb.items_noted, sb.op_seen[ptca_pkg::OP_APPEND], sb.op_seen[ptca_pkg::OP_LCA],
               sb.op_seen[ptca_pkg::OP_ANC], sb.op_seen[ptca_pkg::OP_CLEAR]);
      $display("Answers: %0d ok, %0d out of range, %0d table full; longest walk %0d links.",
               sb.status_seen[ptca_pkg::STAT_OK], sb.status_seen[ptca_pkg::STAT_RANGE],
               sb.status_seen[ptca_pkg::STAT_FULL], sb.deepest_walk);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #200ms;
      $display("Timeout");
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> path_tree_common_ancestor.f
hdl/ptca_pkg.sv
hdl/ptca_parent_ram.sv
hdl/ptca_seq.sv
hdl/path_tree_common_ancestor.sv
hdl/ptca_checker.sv
tb/path_tree_common_ancestor_tb.sv
